>>> rtl/tmft_pkg.sv
`default_nettype none

package tmft_pkg;

    // Field widths fixed by the interface
    localparam int IN_W       = 24;   // delta_us
    localparam int OUT_W      = 28;   // mean_q4
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 32;

    // Defaults for the top-level parameters
    localparam int WINDOW_DEF       = 11;
    localparam int TRIM_DEF         = 2;
    localparam int SAMPLE_WIDTH_DEF = 24;
    localparam int FRAC_BITS_DEF    = 4;

    // Every ring entry holds this after reset
    localparam int unsigned RESET_SAMPLE = 16667;

    // Quotient bits retired per divider cycle
    localparam int DIV_STEP = 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RANK,
        ST_DLOAD,
        ST_DIV,
        ST_OUT
    } tmft_state_t;

    typedef struct packed {
        logic sample_write;  // store sample, clear rank index and sum
        logic rank_step;     // rank one entry, add it if inside the kept band
        logic div_load;      // load scaled sum into the divider
        logic div_step;      // one group of quotient bits
        logic out_load;      // move quotient into the output register
    } tmft_cmd_t;

    typedef struct packed {
        logic rank_last;
        logic div_last;
        logic out_free;
    } tmft_status_t;

endpackage

`default_nettype wire

>>> rtl/tmft_ctrl.sv
`default_nettype none

module tmft_ctrl
    import tmft_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire tmft_status_t status,
    output tmft_cmd_t         cmd
);

    tmft_state_t state_reg;
    tmft_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.sample_write = 1'b1;
                    state_next       = ST_RANK;
                end
            end
            ST_RANK:
            begin
                cmd.rank_step = 1'b1;
                if (status.rank_last)
                begin
                    state_next = ST_DLOAD;
                end
            end
            ST_DLOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // wait until the previous beat has left
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/tmft_dp.sv
`default_nettype none

module tmft_dp
    import tmft_pkg::*;
#(
    parameter int WINDOW       = WINDOW_DEF,
    parameter int TRIM         = TRIM_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [IN_W-1:0]  delta_us,
    input  wire tmft_cmd_t        cmd,
    output tmft_status_t          status,
    input  wire logic             m_tready,
    output logic                  m_tvalid,
    output logic [OUT_W-1:0]      mean_q4
);

    localparam int IDX_W    = $clog2(WINDOW);
    localparam int CNT_W    = $clog2(WINDOW + 1);
    localparam int SUM_W    = SAMPLE_WIDTH + $clog2(WINDOW);
    localparam int DVD_W    = SUM_W + FRAC_BITS;
    localparam int DIV_CYC  = (DVD_W + DIV_STEP - 1) / DIV_STEP;
    localparam int QW       = DIV_CYC * DIV_STEP;
    localparam int KEPT     = WINDOW - 2 * TRIM;
    // empty band sums to zero; dividing by one then yields zero
    localparam int KEPT_EFF = (KEPT > 0) ? KEPT : 1;
    localparam int REM_W    = $clog2(KEPT_EFF + 1) + 1;
    localparam int DCNT_W   = $clog2(DIV_CYC + 1);
    localparam int HI       = WINDOW - TRIM;

    logic [SAMPLE_WIDTH-1:0] ring_reg [WINDOW];
    logic [IDX_W-1:0]        slot_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic [SUM_W-1:0]        acc_reg;
    logic [QW-1:0]           q_reg;
    logic [QW-1:0]           q_next;
    logic [REM_W-1:0]        rem_reg;
    logic [REM_W-1:0]        rem_next;
    logic [DCNT_W-1:0]       dcnt_reg;
    logic                    m_tvalid_reg;
    logic [OUT_W-1:0]        mean_reg;

    logic [SAMPLE_WIDTH-1:0] sample_sat;
    logic [SAMPLE_WIDTH-1:0] cur;
    logic [WINDOW-1:0]       lt;
    logic [CNT_W-1:0]        cnt;
    logic                    keep;
    logic [OUT_W-1:0]        mean_sat;

    // clamp input to the stored sample width
    generate
        if (SAMPLE_WIDTH >= IN_W)
        begin : g_wide
            assign sample_sat = SAMPLE_WIDTH'(delta_us);
        end
        else
        begin : g_narrow
            assign sample_sat = (|delta_us[IN_W-1:SAMPLE_WIDTH]) ?
                                {SAMPLE_WIDTH{1'b1}} : delta_us[SAMPLE_WIDTH-1:0];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < WINDOW; k++)
            begin
                ring_reg[k] <= SAMPLE_WIDTH'(RESET_SAMPLE);
            end
            slot_reg <= '0;
        end
        else if (cmd.sample_write)
        begin
            ring_reg[slot_reg] <= sample_sat;
            slot_reg <= (slot_reg == IDX_W'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
        end
    end

    // stable rank: ties broken by ring position
    always_comb
    begin
        cur = ring_reg[idx_reg];
        for (int j = 0; j < WINDOW; j++)
        begin
            lt[j] = (ring_reg[j] < cur) ||
                    ((ring_reg[j] == cur) && (IDX_W'(j) < idx_reg));
        end
        cnt  = CNT_W'($countones(lt));
        keep = (int'(cnt) >= TRIM) && (int'(cnt) < HI);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sample_write)
        begin
            idx_reg <= '0;
            acc_reg <= '0;
        end
        else if (cmd.rank_step)
        begin
            idx_reg <= idx_reg + 1'b1;
            if (keep)
            begin
                acc_reg <= acc_reg + SUM_W'(cur);
            end
        end
    end

    // restoring division by a constant, DIV_STEP bits per cycle
    always_comb
    begin
        logic [REM_W-1:0] t;
        logic [QW-1:0]    q;
        q = q_reg;
        t = rem_reg;
        for (int s = 0; s < DIV_STEP; s++)
        begin
            t = {t[REM_W-2:0], q[QW-1]};
            q = {q[QW-2:0], 1'b0};
            if (t >= REM_W'(KEPT_EFF))
            begin
                t    = t - REM_W'(KEPT_EFF);
                q[0] = 1'b1;
            end
        end
        q_next   = q;
        rem_next = t;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            q_reg    <= QW'(acc_reg) << FRAC_BITS;
            rem_reg  <= '0;
            dcnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            q_reg    <= q_next;
            rem_reg  <= rem_next;
            dcnt_reg <= dcnt_reg + 1'b1;
        end
    end

    generate
        if (QW > OUT_W)
        begin : g_sat
            assign mean_sat = (|q_reg[QW-1:OUT_W]) ? {OUT_W{1'b1}} : q_reg[OUT_W-1:0];
        end
        else
        begin : g_nosat
            assign mean_sat = OUT_W'(q_reg);
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            mean_reg <= mean_sat;
        end
    end

    assign status.rank_last = (idx_reg == IDX_W'(WINDOW - 1));
    assign status.div_last  = (dcnt_reg == DCNT_W'(DIV_CYC - 1));
    assign status.out_free  = !m_tvalid_reg || m_tready;
    assign m_tvalid         = m_tvalid_reg;
    assign mean_q4          = mean_reg;

endmodule

`default_nettype wire

>>> rtl/trimmed_mean_frame_time.sv
// Flow: IDLE takes a beat, RANK passes over the ring one entry per cycle, DLOAD loads the
//   dividend of SAMPLE_WIDTH + clog2(WINDOW) + FRAC_BITS bits, DIV runs the 8-bit-per-cycle
//   constant divider, and OUT waits while a previous beat is pending and m_tready is low.
//   A new input is accepted only once the result is loaded and the FSM is back in IDLE.
// Reset (rst_n, async, active low): ring entries all 16667, write slot 0, FSM idle,
//   no output beat pending. No clearing pass; an input is accepted right after reset.
`default_nettype none

module trimmed_mean_frame_time
    import tmft_pkg::*;
#(
    parameter int WINDOW       = WINDOW_DEF,        // ring depth, 5..32
    parameter int TRIM         = TRIM_DEF,          // dropped at each end, 1..8
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,  // stored sample width, 16..40
    parameter int FRAC_BITS    = FRAC_BITS_DEF      // fraction bits of the mean, 0..16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // [23:0] delta_us
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata    // [27:0] mean_q4, [31:28] zero
);

    // Flow: an accepted beat is written over the oldest ring entry. The
    // controller then walks the ring one entry per cycle; each entry is ranked
    // against all others in parallel (ties ordered by position) and summed
    // if its rank falls inside the kept band. The sum, scaled by 2^FRAC_BITS,
    // goes through a restoring divider by the kept count. The quotient is
    // clamped to 28 bits and parked in the output register, so a new input
    // beat can be accepted while the previous result waits for m_tready.

    tmft_cmd_t        cmd;
    tmft_status_t     status;
    logic [OUT_W-1:0] mean_q4;

    tmft_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tmft_dp #(
        .WINDOW       (WINDOW),
        .TRIM         (TRIM),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .FRAC_BITS    (FRAC_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .delta_us (s_tdata[IN_W-1:0]),
        .cmd      (cmd),
        .status   (status),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .mean_q4  (mean_q4)
    );

    assign m_tdata = M_TDATA_W'(mean_q4);

`ifndef SYNTHESIS
    // one beat at a time: input closes right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item is in flight");

    // a result never overwrites a beat still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("output register overwritten");

    // loading the output returns the block to idle
    a_back_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> (s_tready && m_tvalid))
        else $error("no return to idle after output load");
`endif

endmodule

`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import tmft_pkg::*;

    // Window geometry at the default parameters of the block
    localparam int KEPT    = WINDOW_DEF - 2 * TRIM_DEF;      // 7 values survive the trim
    localparam int MEAN_W  = IN_W + FRAC_BITS_DEF + 8;       // room for sum * 16 before divide
    localparam logic [MEAN_W-1:0] OUT_MAX = (MEAN_W'(1) << OUT_W) - 1;
    localparam logic [IN_W-1:0]   SAMPLE_MAX = '1;

    // Run control
    localparam int LIMIT_CYCLES = 200000;   // watchdog limit for the whole run
    localparam int DRAIN_CYCLES = 40;       // extra wait after the last expected beat
    localparam int LONG_HOLD    = 400;      // receiver back-pressure stretch
    localparam int RANDOM_ITEMS = 450;

    // ------------------------------------------------------------------
    // Predictor + result checker for the trimmed-mean window
    // ------------------------------------------------------------------
    class trimmed_mean_tracker;
        logic [IN_W-1:0]  ring[WINDOW_DEF];   // insertion order, oldest overwritten
        int unsigned      slot;
        logic [OUT_W-1:0] pending_means[$];
        int               mismatches;

        function new();
            int i;
            for (i = 0; i < WINDOW_DEF; i++)
                ring[i] = IN_W'(RESET_SAMPLE);
            slot       = 0;
            mismatches = 0;
        endfunction

        // one accepted delta_us beat -> one expected mean_q4
        function void note_sample(logic [IN_W-1:0] delta);
            logic [IN_W-1:0]   ranked[WINDOW_DEF];
            logic [IN_W-1:0]   key;
            logic [MEAN_W-1:0] mean;
            int                i;
            int                j;
            // sample width equals the field width here, so no clamp on store
            ring[slot] = delta;
            slot       = (slot + 1) % WINDOW_DEF;

            // rank a copy; the ring itself keeps its order
            ranked = ring;
            for (i = 1; i < WINDOW_DEF; i++)
            begin
                key = ranked[i];
                j   = i - 1;
                while (j >= 0 && ranked[j] > key)
                begin
                    ranked[j + 1] = ranked[j];
                    j--;
                end
                ranked[j + 1] = key;
            end

            mean = '0;
            if (KEPT > 0)
            begin
                for (i = TRIM_DEF; i < WINDOW_DEF - TRIM_DEF; i++)
                    mean += ranked[i];
                mean = (mean << FRAC_BITS_DEF) / KEPT;
                if (mean > OUT_MAX)
                    mean = OUT_MAX;
            end
            pending_means.push_back(mean[OUT_W-1:0]);
        endfunction

        function void check_mean(logic [OUT_W-1:0] got);
            logic [OUT_W-1:0] want;
            if (pending_means.size() == 0)
            begin
                $display("%0t: mean_q4 beat 0x%07h with none expected", $time, got);
                mismatches++;
            end
            else
            begin
                want = pending_means.pop_front();
                if (got !== want)
                begin
                    $display("%0t: mean_q4 expected 0x%07h actual 0x%07h", $time, want, got);
                    mismatches++;
                end
            end
        endfunction

        function int pending();
            return pending_means.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------
    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;     // [23:0] delta_us
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;     // [27:0] mean_q4, [31:28] zero

    trimmed_mean_tracker tracker = new();

    bit tx_idle;      // sender may insert gaps
    bit rx_idle;      // receiver may insert stalls
    bit hold_req;     // ask the receiver for one long hold-off
    int cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    trimmed_mean_frame_time dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // ------------------------------------------------------------------
    // Monitors: sample at the edge, before the DUT's updates land
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n && s_tvalid && s_tready)
            tracker.note_sample(s_tdata[IN_W-1:0]);
        if (rst_n && m_tvalid && m_tready)
            tracker.check_mean(m_tdata[OUT_W-1:0]);
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        wait (cycle_count >= LIMIT_CYCLES);
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: short random stalls, or one long hold-off on request.
    // During the long hold the sender keeps pushing, so the block backs up
    // and has to drop s_tready.
    // ------------------------------------------------------------------
    initial
    begin
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                m_tready <= 1'b1;
            end
            else if (rx_idle && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    // Present one delta_us beat and hold it until taken. Called at an edge;
    // returns at the edge where the beat was accepted.
    task automatic send_sample(input logic [IN_W-1:0] delta);
        if (tx_idle && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(delta);
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Mostly frame-like traces: steady 60/120/30/144 Hz jitter with the
    // odd hitch, plus full-range noise so every bit of delta_us toggles.
    function automatic logic [IN_W-1:0] pick_sample();
        int unsigned kind;
        int unsigned base;
        kind = $urandom_range(0, 99);
        if (kind < 40)
            return IN_W'($urandom_range(16167, 17167));
        else if (kind < 55)
        begin
            case ($urandom_range(0, 2))
                0:       base = 8333;
                1:       base = 33333;
                default: base = 6944;
            endcase
            return IN_W'(base - 400 + $urandom_range(0, 800));
        end
        else if (kind < 70)
            return IN_W'($urandom_range(40000, 2000000));      // load hitch
        else if (kind < 82)
            return IN_W'($urandom_range(0, 24'hFFFFFF));
        else if (kind < 92)
            return IN_W'($urandom_range(0, 255));
        else
            return ($urandom_range(0, 1) == 0) ? '0 : SAMPLE_MAX;
    endfunction

    initial
    begin
        int i;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        tx_idle  = 1'b1;
        rx_idle  = 1'b1;
        hold_req = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes and bit patterns against the reset window
        send_sample('0);
        send_sample(IN_W'(1));
        send_sample(SAMPLE_MAX);
        send_sample(IN_W'(24'hAAAAAA));
        send_sample(IN_W'(24'h555555));
        // whole window at full scale: mean is 0xFFFFFF0, just below the top of the output range
        for (i = 0; i < WINDOW_DEF; i++)
            send_sample(SAMPLE_MAX);
        // zeros push in; a full-scale value stays inside the kept band
        for (i = 0; i < 8; i++)
            send_sample('0);

        // Random frame traces
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            // a stretch with both sides flat out, then gaps again,
            // and a clean run over the last part
            tx_idle = !((i >= 150 && i < 200) || i >= 390);
            rx_idle = tx_idle;
            if (i == 220)
                hold_req = 1'b1;
            send_sample(pick_sample());
        end
        s_tvalid <= 1'b0;

        // let the monitor log the last beat before looking at the backlog
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> trimmed_mean_frame_time.f
rtl/tmft_pkg.sv
rtl/tmft_ctrl.sv
rtl/tmft_dp.sv
rtl/trimmed_mean_frame_time.sv
dv/tb.sv
